// ===== hdl/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // operand width (base, exponent, modulus, result); legal range 8 to 64
    localparam int WIDTH = 64;

    // bit counter width for one modular multiplication
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] t_word;

endpackage
`default_nettype wire

// ===== hdl/modular_exponentiation_64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_64
// base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Busy then stays high
// until the result has been shown. The result appears on o_power_result for
// exactly one cycle with o_done high and must be captured then: there is no
// way to hold it off. All arithmetic runs through one bit-serial modular
// multiplier. Each product holds the sequencer through a start step, WIDTH
// bit steps and a done step. An item needs one product to reduce the base.
// Then, for each exponent bit up to the highest set one, it passes the
// decision state, a square, and a multiply when the bit is set. A last
// decision finds the exponent used up and the finish state shows the result.
// An exponent of zero goes from the reduction through the decision state
// straight to the finish state. A modulus of zero skips the multiplier and
// gives 0 in the cycle after the word is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_64 (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire mexp_pkg::t_word i_base_value,
    input  wire mexp_pkg::t_word i_exponent_value,
    input  wire mexp_pkg::t_word i_modulus_value,
    output logic                 o_done,
    output mexp_pkg::t_word      o_power_result
);
    import mexp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic       r_go;
    t_word      r_m;
    t_word      r_exp;
    t_word      r_base;
    t_word      r_acc;
    t_word      r_sq;

    t_word      w_x;
    t_word      w_y;
    logic       w_done;
    t_word      w_res;

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_RED: begin
                w_x = r_acc;
                w_y = r_base;
            end
            S_MUL: begin
                w_x = r_acc;
                w_y = r_sq;
            end
            default: begin
                w_x = r_sq;
                w_y = r_sq;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_go),
        .i_x      (w_x),
        .i_y      (w_y),
        .i_m      (r_m),
        .o_done   (w_done),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_modulus_value == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RED;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_RED: begin
                    if (w_done) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_exp == '0) begin
                        r_state <= S_FIN;
                    end else if (r_exp[0]) begin
                        r_state <= S_MUL;
                        r_go    <= 1'b1;
                    end else begin
                        r_state <= S_SQR;
                        r_go    <= 1'b1;
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        r_state <= S_SQR;
                        r_go    <= 1'b1;
                    end
                end
                S_SQR: begin
                    if (w_done) begin
                        r_state <= S_PICK;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_m    <= i_modulus_value;
            r_exp  <= i_exponent_value;
            r_base <= i_base_value;
            // 1 mod m: zero for a modulus of one, and zero result for modulus zero
            r_acc  <= (i_modulus_value == t_word'(1) || i_modulus_value == '0) ?
                      '0 : t_word'(1);
        end
        if (w_done) begin
            case (r_state)
                S_RED: begin
                    r_sq <= w_res;
                end
                S_MUL: begin
                    r_acc <= w_res;
                end
                S_SQR: begin
                    r_sq  <= w_res;
                    r_exp <= r_exp >> 1;
                end
                default: begin
                    r_sq <= r_sq;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_FIN);
    assign o_power_result = r_acc;

endmodule
`default_nettype wire

// ===== hdl/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: x * y mod m by double-and-add, one bit of y
// per cycle from the top, reduced at every step. Needs x < m.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire mexp_pkg::t_word i_x,
    input  wire mexp_pkg::t_word i_y,
    input  wire mexp_pkg::t_word i_m,
    output logic                o_done,
    output mexp_pkg::t_word     o_result
);
    import mexp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_word             r_acc;
    t_word             r_y;

    logic [WIDTH+1:0]  w_sum;
    logic [WIDTH+1:0]  w_m1;
    logic [WIDTH+1:0]  w_m2;
    t_word             n_acc;

    // 2*acc + bit*x stays below 3m: subtract m or 2m to bring it back
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + {2'b00, (r_y[WIDTH-1] ? i_x : '0)};
        w_m1  = {2'b00, i_m};
        w_m2  = {1'b0, i_m, 1'b0};
        if (w_sum >= w_m2) begin
            n_acc = t_word'(w_sum - w_m2);
        end else if (w_sum >= w_m1) begin
            n_acc = t_word'(w_sum - w_m1);
        end else begin
            n_acc = t_word'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire
